[rtl/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define FFGR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define FFGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ffgr_pkg.sv]
// Package with the table sizes, item kinds and entry type of the gap reserver.
package ffgr_pkg;

  localparam int MAX_GAPS = 64;
  localparam int IDX_W    = $clog2(MAX_GAPS);
  localparam int CNT_W    = $clog2(MAX_GAPS + 1);

  localparam logic [1:0] KIND_RESTART = 2'd0;
  localparam logic [1:0] KIND_LOAD    = 2'd1;
  localparam logic [1:0] KIND_RESERVE = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // One table entry: a gap from t_start to t_end with free nodes.
  typedef struct packed {
    logic [31:0] t_start;
    logic [31:0] t_end;
    logic [15:0] nodes;
  } gap_t;

  localparam int GAP_W = $bits(gap_t);

endpackage

[rtl/ffgr_in_if.sv]
// Input channel carrying one item per beat.
interface ffgr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] gap_start;
  logic [31:0] gap_end;
  logic [15:0] node_count;
  logic [31:0] duration;

  modport source (output valid, kind, gap_start, gap_end, node_count, duration, input ready);
  modport sink   (input valid, kind, gap_start, gap_end, node_count, duration, output ready);
endinterface

[rtl/ffgr_out_if.sv]
// Output channel carrying one result per beat.
interface ffgr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_time;
  logic        fit_found;
  logic        table_full;
  logic [31:0] last_end;
  logic [6:0]  gap_count;

  modport source (output valid, start_time, fit_found, table_full, last_end, gap_count,
                  input ready);
  modport sink   (input valid, start_time, fit_found, table_full, last_end, gap_count,
                  output ready);
endinterface

[rtl/first_fit_time_gap_reserver_unit.sv]
// Top level of the first-fit time gap reserver.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   kind, gap_start, gap_end, node_count, duration
//   out_ch   out  valid/ready   start_time, fit_found, table_full, last_end, gap_count
//
// Restart, load and unused kinds go from accept through the finishing state to the result.
// A reserve reads and compacts each of the N gaps before it, shifts up the S entries
// above the fitting gap and, when a slice is inserted, writes the slice and the rest;
// the gap table RAM has a single read port with registered read data.
// Reset (rst, synchronous) empties the table and drops any pending result.
// One item is worked at a time; a finished result waits in the output register.
module first_fit_time_gap_reserver_unit
  import ffgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ffgr_in_if.sink    in_ch,
  ffgr_out_if.source out_ch
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_GAPS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CRD, ST_CPROC, ST_EVAL, ST_SRD, ST_SWR, ST_INS1, ST_INS2, ST_FIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [31:0]      last_end;
  logic [31:0]      last_tmp;
  logic [IDX_W-1:0] rd;
  logic [CNT_W-1:0] wr;
  logic [CNT_W-1:0] k;
  logic             hit;
  logic [IDX_W-1:0] fi;
  logic [31:0]      fs;
  logic [31:0]      fe;
  logic [15:0]      fn;
  logic [15:0]      nc;
  logic [31:0]      dur;
  logic [31:0]      res_start;
  logic             res_fit;
  logic             res_full;

  logic             out_valid;
  logic [31:0]      o_start;
  logic             o_fit;
  logic             o_full;
  logic [31:0]      o_last;
  logic [CNT_W-1:0] o_count;

  logic             accept;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  gap_t             wdata;
  gap_t             rdata;
  logic [GAP_W-1:0] rdata_raw;
  gap_t             in_gap;
  logic [31:0]      span;
  logic             keep;
  logic             fits;
  logic [15:0]      left;
  logic [31:0]      new_start;
  logic [CNT_W-1:0] k_m1;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign rdata     = gap_t'(rdata_raw);
  assign in_gap    = '{t_start: in_ch.gap_start, t_end: in_ch.gap_end, nodes: in_ch.node_count};

  // Entry tests during the compaction pass.
  assign span      = (rdata.t_end > rdata.t_start) ? (rdata.t_end - rdata.t_start) : 32'd0;
  assign keep      = (rdata.nodes != 16'd0) && (span != 32'd0);
  assign fits      = (rdata.nodes >= nc) && (span >= dur);
  assign left      = fn - nc;
  assign new_start = fs + dur;
  assign k_m1      = k - CNT_W'(1);

  // RAM port control.
  always_comb begin
    we    = 1'b0;
    waddr = fi;
    wdata = rdata;
    raddr = rd;
    unique case (state)
      ST_IDLE: begin
        wdata = in_gap;
        if (accept && in_ch.kind == KIND_RESTART) begin
          we    = 1'b1;
          waddr = '0;
        end else if (accept && in_ch.kind == KIND_LOAD) begin
          we    = (count < MAX_CNT);
          waddr = count[IDX_W-1:0];
        end
      end
      ST_CRD: raddr = rd;
      ST_CPROC: begin
        we    = keep;
        waddr = wr[IDX_W-1:0];
      end
      ST_EVAL: begin
        we    = hit && (left == 16'd0);
        wdata = '{t_start: new_start, t_end: fe, nodes: fn};
      end
      ST_SRD: raddr = k_m1[IDX_W-1:0];
      ST_SWR: begin
        we    = 1'b1;
        waddr = k[IDX_W-1:0];
      end
      ST_INS1: begin
        we    = 1'b1;
        wdata = '{t_start: fs, t_end: new_start, nodes: left};
      end
      ST_INS2: begin
        we    = 1'b1;
        waddr = fi + IDX_W'(1);
        wdata = '{t_start: new_start, t_end: fe, nodes: fn};
      end
      default: we = 1'b0;
    endcase
  end

  ffgr_ram #(.DEPTH(MAX_GAPS), .WIDTH(GAP_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // Sequencer: restart and load, or compaction with first-fit search, then shift and insert.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      last_end  <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finishing state reloads the output register on its own.
      if (out_valid && out_ch.ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            nc        <= in_ch.node_count;
            dur       <= in_ch.duration;
            res_start <= '0;
            res_fit   <= 1'b0;
            res_full  <= 1'b0;
            rd        <= '0;
            wr        <= '0;
            hit       <= 1'b0;
            last_tmp  <= '0;
            unique case (in_ch.kind)
              KIND_RESTART: begin
                count    <= CNT_W'(1);
                last_end <= in_ch.gap_end;
                state    <= ST_FIN;
              end
              KIND_LOAD: begin
                if (count < MAX_CNT) begin
                  count    <= count + CNT_W'(1);
                  last_end <= in_ch.gap_end;
                end else begin
                  res_full <= 1'b1;
                end
                state <= ST_FIN;
              end
              KIND_RESERVE: state <= (count == '0) ? ST_EVAL : ST_CRD;
              KIND_NONE:    state <= ST_FIN;
            endcase
          end
        end
        ST_CRD: state <= ST_CPROC;
        ST_CPROC: begin
          if (keep) begin
            wr       <= wr + CNT_W'(1);
            last_tmp <= rdata.t_end;
            if (!hit && fits) begin
              hit <= 1'b1;
              fi  <= wr[IDX_W-1:0];
              fs  <= rdata.t_start;
              fe  <= rdata.t_end;
              fn  <= rdata.nodes;
            end
          end
          rd    <= rd + IDX_W'(1);
          state <= ({1'b0, rd} + CNT_W'(1) == count) ? ST_EVAL : ST_CRD;
        end
        ST_EVAL: begin
          count    <= wr;
          last_end <= last_tmp;
          k        <= wr;
          if (!hit) begin
            state <= ST_FIN;
          end else if (left == 16'd0) begin
            res_fit   <= 1'b1;
            res_start <= fs;
            state     <= ST_FIN;
          end else if (wr >= MAX_CNT) begin
            res_full <= 1'b1;
            state    <= ST_FIN;
          end else begin
            state <= (wr > {1'b0, fi}) ? ST_SRD : ST_INS1;
          end
        end
        ST_SRD: state <= ST_SWR;
        ST_SWR: begin
          k     <= k_m1;
          state <= (k_m1 > {1'b0, fi}) ? ST_SRD : ST_INS1;
        end
        ST_INS1: state <= ST_INS2;
        ST_INS2: begin
          count     <= count + CNT_W'(1);
          res_fit   <= 1'b1;
          res_start <= fs;
          state     <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            o_start   <= res_start;
            o_fit     <= res_fit;
            o_full    <= res_full;
            o_last    <= last_end;
            o_count   <= count;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.start_time = o_start;
  assign out_ch.fit_found  = o_fit;
  assign out_ch.table_full = o_full;
  assign out_ch.last_end   = o_last;
  assign out_ch.gap_count  = 7'(o_count);

endmodule

[rtl/ffgr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ffgr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/ffgr_chk.sv]
// Port-level checker for the gap reserver, bound to the top level.
`include "assert_macros.svh"

module ffgr_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] start_time,
  input logic        fit_found,
  input logic        table_full,
  input logic [6:0]  gap_count
);

  `FFGR_ASSERT(a_flags_excl, clk, rst, out_valid |-> !(fit_found && table_full), "fit and full both set")
  `FFGR_ASSERT(a_start_zero, clk, rst, (out_valid && !fit_found) |-> (start_time == 32'd0), "start without fit")
  `FFGR_ASSERT(a_count_max, clk, rst, out_valid |-> (gap_count <= 7'd64), "gap count too large")
  `FFGR_ASSERT(a_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(start_time)), "stalled beat changed")
  `FFGR_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid, "result beat after reset")

endmodule

bind first_fit_time_gap_reserver_unit ffgr_chk u_ffgr_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .start_time (out_ch.start_time),
  .fit_found  (out_ch.fit_found),
  .table_full (out_ch.table_full),
  .gap_count  (out_ch.gap_count)
);

[verif/ffgr_tb_if.sv]
// Testbench-side copies of the gap reserver channel interfaces are not needed; this file holds the beat record types.
package ffgr_tb_pkg;
  import ffgr_pkg::*;

  // One input beat as the testbench builds it.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] gap_start;
    logic [31:0] gap_end;
    logic [15:0] node_count;
    logic [31:0] duration;
  } item_beat_t;

  // One result beat as the block reports it.
  typedef struct {
    logic [31:0] start_time;
    logic        fit_found;
    logic        table_full;
    logic [31:0] last_end;
    logic [6:0]  gap_count;
  } result_beat_t;
endpackage

[verif/first_fit_time_gap_reserver_unit_tb.sv]
// Testbench for the first-fit time gap reserver: directed table, random items, predictor check.
module first_fit_time_gap_reserver_unit_tb;
  import ffgr_pkg::*;
  import ffgr_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffgr_in_if  in_ch ();
  ffgr_out_if out_ch ();

  first_fit_time_gap_reserver_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #10 clk = ~clk;

  // Shadow gap table kept by the predictor.
  gap_t        shadow_gaps [MAX_GAPS];
  int unsigned shadow_used;

  result_beat_t awaited_results [$];
  int           mismatch_count = 0;
  int           results_seen = 0;
  int           fits_seen = 0;
  int           fulls_seen = 0;
  int           idle_cycles = 0;
  bit           sending_done;
  bit           hold_receiver;

  function automatic logic [31:0] gap_span(logic [31:0] s, logic [31:0] e);
    return (e > s) ? e - s : 32'd0;
  endfunction

  // Work out the result of one item and update the shadow table.
  function automatic result_beat_t predict_reservation(item_beat_t it);
    result_beat_t r;
    int unsigned wr;
    logic [15:0] left;
    gap_t g;
    r = '{32'd0, 1'b0, 1'b0, 32'd0, 7'd0};
    case (it.kind)
      KIND_RESTART: begin
        shadow_gaps[0] = '{it.gap_start, it.gap_end, it.node_count};
        shadow_used = 1;
      end
      KIND_LOAD: begin
        if (shadow_used < MAX_GAPS) begin
          shadow_gaps[shadow_used] = '{it.gap_start, it.gap_end, it.node_count};
          shadow_used++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      KIND_RESERVE: begin
        // Drop empty and zero-length gaps, keeping order.
        wr = 0;
        for (int unsigned rd = 0; rd < shadow_used; rd++) begin
          if (shadow_gaps[rd].nodes != 0 &&
              gap_span(shadow_gaps[rd].t_start, shadow_gaps[rd].t_end) != 0) begin
            shadow_gaps[wr] = shadow_gaps[rd];
            wr++;
          end
        end
        shadow_used = wr;
        // First fit, with a slice inserted for leftover nodes.
        for (int unsigned i = 0; i < shadow_used; i++) begin
          g = shadow_gaps[i];
          if (g.nodes >= it.node_count && gap_span(g.t_start, g.t_end) >= it.duration) begin
            left = g.nodes - it.node_count;
            if (left != 0) begin
              if (shadow_used >= MAX_GAPS) begin
                r.table_full = 1'b1;
                break;
              end
              for (int unsigned k = shadow_used; k > i; k--) shadow_gaps[k] = shadow_gaps[k-1];
              shadow_gaps[i] = '{g.t_start, g.t_start + it.duration, left};
              shadow_used++;
              shadow_gaps[i+1].t_start = g.t_start + it.duration;
            end else begin
              shadow_gaps[i].t_start = g.t_start + it.duration;
            end
            r.start_time = g.t_start;
            r.fit_found  = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    if (shadow_used > 0) r.last_end = shadow_gaps[shadow_used-1].t_end;
    r.gap_count = shadow_used[6:0];
    return r;
  endfunction

  // Send one beat after a random gap, then queue its prediction or a typed-in one.
  task automatic send_item(item_beat_t it, bit use_typed, result_beat_t typed);
    result_beat_t p;
    int gap;
    gap = (sending_done || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    // Valid drops only when the next beat does not follow at once.
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= it.kind;
    in_ch.gap_start  <= it.gap_start;
    in_ch.gap_end    <= it.gap_end;
    in_ch.node_count <= it.node_count;
    in_ch.duration   <= it.duration;
    do @(posedge clk); while (!in_ch.ready);
    p = predict_reservation(it);
    if (use_typed) begin
      p = typed;
    end
    awaited_results = {awaited_results, p};
  endtask

  function automatic item_beat_t mk(logic [1:0] k, logic [31:0] s, logic [31:0] e,
                                    logic [15:0] n, logic [31:0] d);
    item_beat_t it;
    it = '{k, s, e, n, d};
    return it;
  endfunction

  // Directed rows: item, whether the result is typed in, and that result.
  item_beat_t   dir_items [$];
  bit           dir_typed [$];
  result_beat_t dir_results [$];

  task automatic add_row(item_beat_t it, bit t, result_beat_t r);
    dir_items   = {dir_items, it};
    dir_typed   = {dir_typed, t};
    dir_results = {dir_results, r};
  endtask

  // One random item: mostly reserves, with restarts, loads and full-width noise mixed in.
  task automatic send_random_item();
    int sel;
    logic [31:0] base;
    item_beat_t it;
    sel = $urandom_range(0, 99);
    base = $urandom_range(0, 1000);
    if (sel < 4) begin
      it = mk(KIND_RESTART, base, base + $urandom_range(0, 5000),
              16'($urandom_range(0, 64)), 32'd0);
    end else if (sel < 25) begin
      it = mk(KIND_LOAD, base * 3, base * 3 + $urandom_range(0, 800),
              16'($urandom_range(0, 40)), $urandom);
    end else if (sel < 90) begin
      it = mk(KIND_RESERVE, $urandom, $urandom, 16'($urandom_range(0, 24)),
              $urandom_range(0, 300));
    end else if (sel < 95) begin
      // Noise with full-width random fields.
      it = mk(2'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom), $urandom);
      if (it.kind == KIND_RESTART) it.node_count = 16'($urandom);
    end else begin
      it = mk(KIND_RESERVE, $urandom, $urandom, 16'($urandom), $urandom);
    end
    send_item(it, 1'b0, '{0, 0, 0, 0, 0});
  endtask

  // Sender: reset, directed table, fill and stall phase, random items.
  initial begin
    result_beat_t z;
    z = '{32'd0, 1'b0, 1'b0, 32'd0, 7'd0};
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_NONE;
    in_ch.gap_start = '0;
    in_ch.gap_end = '0;
    in_ch.node_count = '0;
    in_ch.duration = '0;
    sending_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then extremes and each special case.
    add_row(mk(KIND_NONE, '1, '1, '1, '1), 1, z);
    add_row(mk(KIND_RESERVE, 0, 0, 0, 0), 1, z);
    add_row(mk(KIND_RESTART, '1, '1, '1, 0), 1, '{0, 0, 0, 32'hFFFF_FFFF, 7'd1});
    add_row(mk(KIND_RESERVE, 0, 0, 1, 0), 1, z);
    add_row(mk(KIND_RESTART, 0, '1, '1, 0), 1, '{0, 0, 0, 32'hFFFF_FFFF, 7'd1});
    add_row(mk(KIND_RESERVE, '1, '1, 16'hFFFF, 32'hFFFF_FFFF), 1,
            '{0, 1, 0, 32'hFFFF_FFFF, 7'd1});
    add_row(mk(KIND_RESTART, 100, 200, 8, 0), 1, '{0, 0, 0, 200, 7'd1});
    add_row(mk(KIND_LOAD, 300, 250, 4, 0), 1, '{0, 0, 0, 250, 7'd2});
    add_row(mk(KIND_LOAD, 400, 900, 0, 0), 1, '{0, 0, 0, 900, 7'd3});
    add_row(mk(KIND_LOAD, 1000, 5000, 32, 0), 1, '{0, 0, 0, 5000, 7'd4});
    add_row(mk(KIND_RESERVE, 0, 0, 8, 50), 0, z);
    add_row(mk(KIND_RESERVE, 0, 0, 3, 0), 0, z);
    add_row(mk(KIND_RESERVE, 0, 0, 2, 40), 0, z);
    add_row(mk(KIND_RESERVE, 0, 0, 33, 1), 0, z);
    add_row(mk(KIND_RESERVE, 0, 0, 1, 4000), 0, z);
    add_row(mk(KIND_RESERVE, 0, 0, 1, 32'hFFFF_FFFF), 0, z);
    add_row(mk(KIND_NONE, 0, 0, 0, 0), 0, z);
    foreach (dir_items[i]) send_item(dir_items[i], dir_typed[i], dir_results[i]);

    // Fill the table past capacity while the receiver holds off.
    hold_receiver = 1'b1;
    send_item(mk(KIND_RESTART, 0, 10, 2, 0), 0, z);
    for (int i = 0; i < MAX_GAPS + 2; i++)
      send_item(mk(KIND_LOAD, 10 * i + 10, 10 * i + 20, 2, 0), 0, z);
    // Reserves on the full table; the second is an exact fit, the others find no room for a slice.
    send_item(mk(KIND_RESERVE, 0, 0, 1, 5), 0, z);
    send_item(mk(KIND_RESERVE, 0, 0, 2, 5), 0, z);
    send_item(mk(KIND_RESERVE, 0, 0, 1, 1), 0, z);

    for (int n = 0; n < 600; n++) send_random_item();
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off counted here.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    hold_receiver = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      out_ch.ready <= 1'b0;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.fit_found) fits_seen++;
      if (out_ch.table_full) fulls_seen++;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result beat at %0t", $realtime);
      end else begin
        want = awaited_results.pop_front();
        if (want.start_time !== out_ch.start_time || want.fit_found !== out_ch.fit_found ||
            want.table_full !== out_ch.table_full || want.last_end !== out_ch.last_end ||
            want.gap_count !== out_ch.gap_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch %0d: expected start %0d fit %0b full %0b end %0d count %0d, got start %0d fit %0b full %0b end %0d count %0d",
                     results_seen, want.start_time, want.fit_found, want.table_full,
                     want.last_end, want.gap_count, out_ch.start_time, out_ch.fit_found,
                     out_ch.table_full, out_ch.last_end, out_ch.gap_count);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", awaited_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // End of run once the sender is done and nothing is outstanding.
  initial begin
    wait (sending_done);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Checked %0d result beats: %0d placed jobs, %0d full-table refusals.",
             results_seen, fits_seen, fulls_seen);
    $display("Mismatches: %0d, results left over: %0d", mismatch_count,
             awaited_results.size());
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[first_fit_time_gap_reserver_unit.f]
+incdir+rtl
rtl/ffgr_pkg.sv
rtl/ffgr_in_if.sv
rtl/ffgr_out_if.sv
rtl/ffgr_ram.sv
rtl/first_fit_time_gap_reserver_unit.sv
rtl/ffgr_chk.sv
verif/ffgr_tb_if.sv
verif/first_fit_time_gap_reserver_unit_tb.sv
